// ===== hdl/min_tracking_stack_defines.svh =====
// ----------------------------------------------------------------------------
// min_tracking_stack_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define MTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion, checked during reset too
`define MTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// types and constants of the minimum tracking stack
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int WORD_W          = 32;
  localparam int ENTRY_W         = 2 * WORD_W;

  localparam logic [WORD_W-1:0] INT_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] INT_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP_RD
  } state_t;

  typedef struct packed {
    logic                     req_type;
    logic signed [WORD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] top_value;
    logic signed [WORD_W-1:0] min_value;
    logic                     is_empty;
    logic [1:0]               status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/mts_ram.sv =====
// ----------------------------------------------------------------------------
// mts_ram
// single port write, single port read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/min_tracking_stack.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack
// bounded stack of signed words that reports the running minimum after each
// push or pop
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command gives
// exactly one result, shown on out_data for one cycle with out_valid high;
// the receiver cannot stall it. A push, a pop on an empty stack and a pop
// that leaves the stack empty show their result the cycle after the transfer.
// A pop that leaves one or more entries reads the new top and its minimum
// from the entry ram, whose read data is registered; busy is high in
// ST_POP_RD, while that read data is taken and the result registered. The top
// value and its minimum are held in registers, so a push needs no ram read. No
// clearing pass follows reset: the ram is only read below the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  output out_item_t      out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [WORD_W-1:0] top_val_r, top_val_nxt;
  logic signed [WORD_W-1:0] top_min_r, top_min_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic                     accept;
  logic                     is_full;
  logic                     pop_read;
  logic signed [WORD_W-1:0] new_min;
  logic [CW-1:0]            count_m2;

  logic                     ram_we;
  logic                     ram_re;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic signed [WORD_W-1:0] rd_val;
  logic signed [WORD_W-1:0] rd_min;

  assign accept   = start && !busy;
  assign is_full  = (count_r == CW'(STACK_DEPTH));
  assign count_m2 = count_r - CW'(2);
  assign pop_read = accept && (in_data.req_type == REQ_POP) && (count_r >= CW'(2));
  assign new_min  = ((count_r != '0) && !(in_data.push_value < top_min_r))
                    ? top_min_r : in_data.push_value;
  assign rd_val   = ram_rdata[ENTRY_W-1:WORD_W];
  assign rd_min   = ram_rdata[WORD_W-1:0];

  mts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_data.push_value, new_min}),
    .re    (ram_re),
    .raddr (count_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop_read) begin
          state_nxt = ST_POP_RD;
        end
      end
      ST_POP_RD: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy          = (state_r == ST_POP_RD);
    count_nxt     = count_r;
    top_val_nxt   = top_val_r;
    top_min_nxt   = top_min_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_PUSH) begin
            out_valid_nxt = 1'b1;
            if (is_full) begin
              out_data_nxt = '{top_value: top_val_r, min_value: top_min_r,
                               is_empty: 1'b0, status: STATUS_PUSH_FULL};
            end else begin
              ram_we       = 1'b1;
              count_nxt    = count_r + CW'(1);
              top_val_nxt  = in_data.push_value;
              top_min_nxt  = new_min;
              out_data_nxt = '{top_value: in_data.push_value, min_value: new_min,
                               is_empty: 1'b0, status: STATUS_OK};
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{top_value: INT_MIN, min_value: INT_MAX,
                              is_empty: 1'b1, status: STATUS_POP_EMPTY};
          end else if (count_r == CW'(1)) begin
            out_valid_nxt = 1'b1;
            count_nxt     = '0;
            out_data_nxt  = '{top_value: INT_MIN, min_value: INT_MAX,
                              is_empty: 1'b1, status: STATUS_OK};
          end else begin
            ram_re    = 1'b1;
            count_nxt = count_r - CW'(1);
          end
        end
      end
      ST_POP_RD: begin
        out_valid_nxt = 1'b1;
        top_val_nxt   = rd_val;
        top_min_nxt   = rd_min;
        out_data_nxt  = '{top_value: rd_val, min_value: rd_min,
                          is_empty: 1'b0, status: STATUS_OK};
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_val_r  <= top_val_nxt;
    top_min_r  <= top_min_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/mts_checker.sv =====
// ----------------------------------------------------------------------------
// mts_checker
// port level checks of the minimum tracking stack, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_tracking_stack_defines.svh"

module mts_checker
  import mts_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire out_item_t out_data
);

  // every transfer gives a result or raises busy in the cycle after it
  `MTS_ASSERT(a_result_follows, (start && !busy) |=> (out_valid || busy), "transfer without result")

  // the ram read of a pop always completes while busy: busy then falls and the result is shown
  `MTS_ASSERT(a_busy_one_cycle, busy |=> (!busy && out_valid), "busy not followed by result")

  // an empty stack reports the sentinel top and minimum
  `MTS_ASSERT(a_empty_values, (out_valid && out_data.is_empty) |->
    (out_data.top_value == INT_MIN && out_data.min_value == INT_MAX), "bad empty outputs")

  // the running minimum never exceeds the top entry
  `MTS_ASSERT(a_min_le_top, (out_valid && !out_data.is_empty) |->
    (out_data.min_value <= out_data.top_value), "minimum above top")

  // a pop on empty reports the stack as empty
  `MTS_ASSERT(a_status_empty, (out_valid && out_data.status == STATUS_POP_EMPTY) |->
    out_data.is_empty, "pop on empty with entries")

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

`default_nettype wire
